[rtl/lookat_view_matrix_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the look-at view matrix block
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOOKAT_VIEW_MATRIX_ASSERT_SVH
`define LOOKAT_VIEW_MATRIX_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LVM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LVM_ASSERT_IMPL(lbl, ante, cons, msg)
`define LVM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/lvm_pkg.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Widths, step types and the shared square-root and division steps.
// ----------------------------------------------------------------------------
package lvm_pkg;

    localparam int WORD_W    = 32;     // every top-level port field
    localparam int UNIT_FRAC = 30;     // Q2.30 fraction bits
    localparam int TOP_BIT   = 30;     // normalized magnitudes peak at this bit
    localparam int MAG_W     = TOP_BIT + 1;
    localparam int PROD_W    = 2 * WORD_W;

    localparam int ROOT_W       = 32;
    localparam int RAD_W        = 2 * ROOT_W;
    localparam int REM_W        = ROOT_W + 1;
    localparam int SQ_PER_STAGE = 2;
    localparam int SQ_STAGES    = ROOT_W / SQ_PER_STAGE;

    localparam int QUO_W        = 32;
    localparam int DV_PER_STAGE = 2;
    localparam int DV_STAGES    = QUO_W / DV_PER_STAGE;
    localparam int NUM_W        = MAG_W + UNIT_FRAC + 1;

    localparam logic [QUO_W-1:0] UNIT_Q30 = QUO_W'(64'd1 << UNIT_FRAC);

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_sq;

    typedef struct packed {
        logic [QUO_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] q;
    } t_dv;

    // One digit of a restoring integer square root.
    function automatic t_sq sqrt_step(t_sq a);
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        t_sq              r;
        cur   = {a.rem, a.rad[RAD_W-1 -: 2]};
        trial = {{(REM_W - ROOT_W){1'b0}}, a.root, 2'b01};
        r.rad = {a.rad[RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
            r.rem  = REM_W'(cur - trial);
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur[REM_W-1:0];
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // One bit of a restoring division by len.
    function automatic t_dv div_step(t_dv a, logic [QUO_W-1:0] len);
        logic [QUO_W:0] cur;
        t_dv            r;
        cur   = {a.rem, a.low[QUO_W-1]};
        r.low = {a.low[QUO_W-2:0], 1'b0};
        if (cur >= {1'b0, len}) begin
            r.rem = QUO_W'(cur - {1'b0, len});
            r.q   = {a.q[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = cur[QUO_W-1:0];
            r.q   = {a.q[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[rtl/lvm_norm.sv]
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a signed 3-vector to Q2.30 unit length through a pipelined square
// root and three pipelined dividers; flags a zero-length vector.
// ----------------------------------------------------------------------------
module lvm_norm
    import lvm_pkg::*;
#(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [2:0][IN_W-1:0]        i_vec,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [2:0][WORD_W-1:0]      o_unit,
    output logic                        o_zero,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int POS_W = $clog2(IN_W);
    localparam logic [POS_W-1:0] TOP_POS = POS_W'(TOP_BIT);

    // Stage 1: sign and magnitude.
    logic [2:0]            n_s1_neg;
    logic [2:0][IN_W-1:0]  n_s1_mag;
    logic                  r_s1_v;
    logic [2:0]            r_s1_neg;
    logic [2:0][IN_W-1:0]  r_s1_mag;
    logic [SIDE_W-1:0]     r_s1_side;

    // Stage 2: leading one of the largest magnitude.
    logic [IN_W-1:0]       n_s2_any;
    logic [POS_W-1:0]      n_s2_pos;
    logic                  r_s2_v;
    logic [2:0]            r_s2_neg;
    logic [2:0][IN_W-1:0]  r_s2_mag;
    logic [POS_W-1:0]      r_s2_pos;
    logic                  r_s2_zero;
    logic [SIDE_W-1:0]     r_s2_side;

    // Stage 3: common shift.
    logic [2:0][MAG_W-1:0] n_s3_m;
    logic                  r_s3_v;
    logic [2:0]            r_s3_neg;
    logic [2:0][MAG_W-1:0] r_s3_m;
    logic                  r_s3_zero;
    logic [SIDE_W-1:0]     r_s3_side;

    // Stage 4: squares.
    logic                      r_s4_v;
    logic [2:0]                r_s4_neg;
    logic [2:0][MAG_W-1:0]     r_s4_m;
    logic [2:0][2*MAG_W-1:0]   r_s4_sq;
    logic                      r_s4_zero;
    logic [SIDE_W-1:0]         r_s4_side;

    // Square root pipeline; entry 0 holds the sum of squares.
    logic                  r_sq_v    [SQ_STAGES+1];
    t_sq                   r_sq_st   [SQ_STAGES+1];
    logic [2:0][MAG_W-1:0] r_sq_m    [SQ_STAGES+1];
    logic [2:0]            r_sq_neg  [SQ_STAGES+1];
    logic                  r_sq_zero [SQ_STAGES+1];
    logic [SIDE_W-1:0]     r_sq_side [SQ_STAGES+1];

    // Divider pipeline; entry 0 holds the rounded numerators.
    logic                  r_dv_v    [DV_STAGES+1];
    t_dv [2:0]             r_dv_st   [DV_STAGES+1];
    logic [QUO_W-1:0]      r_dv_len  [DV_STAGES+1];
    logic [2:0]            r_dv_neg  [DV_STAGES+1];
    logic                  r_dv_zero [DV_STAGES+1];
    logic [SIDE_W-1:0]     r_dv_side [DV_STAGES+1];

    t_dv [2:0]             n_dv_init;
    logic [2:0][NUM_W-1:0] n_num;
    logic [2:0][WORD_W-1:0] n_unit;
    logic [2:0][QUO_W-1:0]  n_clamp;

    logic                   r_out_v;
    logic [2:0][WORD_W-1:0] r_out_unit;
    logic                   r_out_zero;
    logic [SIDE_W-1:0]      r_out_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1_neg[i] = i_vec[i][IN_W-1];
            n_s1_mag[i] = n_s1_neg[i] ? (~i_vec[i] + IN_W'(1)) : i_vec[i];
        end
    end

    always_comb begin
        n_s2_any = r_s1_mag[0] | r_s1_mag[1] | r_s1_mag[2];
        n_s2_pos = '0;
        for (int k = 0; k < IN_W; k++) begin
            if (n_s2_any[k]) begin
                n_s2_pos = POS_W'(k);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_s2_pos > TOP_POS) begin
                n_s3_m[i] = MAG_W'(r_s2_mag[i] >> (r_s2_pos - TOP_POS));
            end else begin
                n_s3_m[i] = MAG_W'(r_s2_mag[i] << (TOP_POS - r_s2_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s4_v    <= 1'b0;
            r_sq_v[0] <= 1'b0;
        end else if (i_en) begin
            r_s1_v    <= i_valid;
            r_s2_v    <= r_s1_v;
            r_s3_v    <= r_s2_v;
            r_s4_v    <= r_s3_v;
            r_sq_v[0] <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_neg  <= n_s1_neg;
            r_s1_mag  <= n_s1_mag;
            r_s1_side <= i_side;

            r_s2_neg  <= r_s1_neg;
            r_s2_mag  <= r_s1_mag;
            r_s2_pos  <= n_s2_pos;
            r_s2_zero <= (n_s2_any == '0);
            r_s2_side <= r_s1_side;

            r_s3_neg  <= r_s2_neg;
            r_s3_m    <= n_s3_m;
            r_s3_zero <= r_s2_zero;
            r_s3_side <= r_s2_side;

            r_s4_neg  <= r_s3_neg;
            r_s4_m    <= r_s3_m;
            r_s4_zero <= r_s3_zero;
            r_s4_side <= r_s3_side;
            for (int i = 0; i < 3; i++) begin
                r_s4_sq[i] <= r_s3_m[i] * r_s3_m[i];
            end

            r_sq_st[0].rem  <= '0;
            r_sq_st[0].root <= '0;
            r_sq_st[0].rad  <= RAD_W'(r_s4_sq[0]) + RAD_W'(r_s4_sq[1]) + RAD_W'(r_s4_sq[2]);
            r_sq_m[0]       <= r_s4_m;
            r_sq_neg[0]     <= r_s4_neg;
            r_sq_zero[0]    <= r_s4_zero;
            r_sq_side[0]    <= r_s4_side;
        end
    end

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
        t_sq n_sq;

        always_comb begin
            n_sq = r_sq_st[s];
            for (int j = 0; j < SQ_PER_STAGE; j++) begin
                n_sq = sqrt_step(n_sq);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_sq_v[s+1] <= r_sq_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_st[s+1]   <= n_sq;
                r_sq_m[s+1]    <= r_sq_m[s];
                r_sq_neg[s+1]  <= r_sq_neg[s];
                r_sq_zero[s+1] <= r_sq_zero[s];
                r_sq_side[s+1] <= r_sq_side[s];
            end
        end
    end

    // Numerator is mag * 2^30 plus half the length, for round to nearest.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = NUM_W'({r_sq_m[SQ_STAGES][i], {UNIT_FRAC{1'b0}}})
                     + NUM_W'(r_sq_st[SQ_STAGES].root >> 1);
            n_dv_init[i].rem = QUO_W'(n_num[i][NUM_W-1:QUO_W]);
            n_dv_init[i].low = n_num[i][QUO_W-1:0];
            n_dv_init[i].q   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_v[0] <= r_sq_v[SQ_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_st[0]   <= n_dv_init;
            r_dv_len[0]  <= r_sq_st[SQ_STAGES].root;
            r_dv_neg[0]  <= r_sq_neg[SQ_STAGES];
            r_dv_zero[0] <= r_sq_zero[SQ_STAGES];
            r_dv_side[0] <= r_sq_side[SQ_STAGES];
        end
    end

    for (genvar s = 0; s < DV_STAGES; s++) begin : g_div
        t_dv [2:0] n_dv;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_dv[i] = r_dv_st[s][i];
                for (int j = 0; j < DV_PER_STAGE; j++) begin
                    n_dv[i] = div_step(n_dv[i], r_dv_len[s]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[s+1] <= r_dv_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_st[s+1]   <= n_dv;
                r_dv_len[s+1]  <= r_dv_len[s];
                r_dv_neg[s+1]  <= r_dv_neg[s];
                r_dv_zero[s+1] <= r_dv_zero[s];
                r_dv_side[s+1] <= r_dv_side[s];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_clamp[i] = (r_dv_st[DV_STAGES][i].q > UNIT_Q30) ? UNIT_Q30
                                                               : r_dv_st[DV_STAGES][i].q;
            if (r_dv_zero[DV_STAGES]) begin
                n_unit[i] = '0;
            end else if (r_dv_neg[DV_STAGES][i]) begin
                n_unit[i] = WORD_W'(~n_clamp[i] + QUO_W'(1));
            end else begin
                n_unit[i] = WORD_W'(n_clamp[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_dv_v[DV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_unit <= n_unit;
            r_out_zero <= r_dv_zero[DV_STAGES];
            r_out_side <= r_dv_side[DV_STAGES];
        end
    end

    assign o_valid = r_out_v;
    assign o_unit  = r_out_unit;
    assign o_zero  = r_out_zero;
    assign o_side  = r_out_side;

endmodule

[rtl/lvm_cross.sv]
// ----------------------------------------------------------------------------
// Cross product
// Exact 64-bit cross product of two signed 32-bit 3-vectors, two stages.
// ----------------------------------------------------------------------------
module lvm_cross
    import lvm_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [2:0][WORD_W-1:0]   i_a,
    input  logic [2:0][WORD_W-1:0]   i_b,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic [2:0][PROD_W-1:0]   o_c,
    output logic [SIDE_W-1:0]        o_side
);

    logic signed [WORD_W-1:0] a0, a1, a2, b0, b1, b2;
    logic signed [PROD_W-1:0] n_p [6];
    logic signed [PROD_W-1:0] r_p [6];
    logic                     r_p_v;
    logic [SIDE_W-1:0]        r_p_side;
    logic                     r_c_v;
    logic [2:0][PROD_W-1:0]   r_c;
    logic [SIDE_W-1:0]        r_c_side;

    always_comb begin
        a0 = i_a[0];
        a1 = i_a[1];
        a2 = i_a[2];
        b0 = i_b[0];
        b1 = i_b[1];
        b2 = i_b[2];
        n_p[0] = a1 * b2;
        n_p[1] = a2 * b1;
        n_p[2] = a2 * b0;
        n_p[3] = a0 * b2;
        n_p[4] = a0 * b1;
        n_p[5] = a1 * b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= i_valid;
            r_c_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p      <= n_p;
            r_p_side <= i_side;
            r_c[0]   <= r_p[0] - r_p[1];
            r_c[1]   <= r_p[2] - r_p[3];
            r_c[2]   <= r_p[4] - r_p[5];
            r_c_side <= r_p_side;
        end
    end

    assign o_valid = r_c_v;
    assign o_c     = r_c;
    assign o_side  = r_c_side;

endmodule

[rtl/lvm_xlate.sv]
// ----------------------------------------------------------------------------
// Translation column
// Minus the dot product of each axis with the eye, rounded from Q2.30 and
// saturated to 32 bits, in three stages.
// ----------------------------------------------------------------------------
module lvm_xlate
    import lvm_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [2:0][2:0][WORD_W-1:0]   i_axis,
    input  logic [2:0][WORD_W-1:0]        i_eye,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [2:0][WORD_W-1:0]        o_shift,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int T_W  = PROD_W + 2;
    localparam int SH_W = T_W - UNIT_FRAC;
    localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(64'sd2147483647);
    localparam logic signed [SH_W-1:0] SAT_MIN = SH_W'(-64'sd2147483648);
    localparam logic signed [T_W-1:0]  HALF    = T_W'(64'd1 << (UNIT_FRAC - 1));

    logic signed [PROD_W-1:0] n_p [3][3];
    logic signed [PROD_W-1:0] r_p [3][3];
    logic signed [PROD_W-1:0] r_s [3];
    logic signed [T_W-1:0]    n_t [3];
    logic signed [SH_W-1:0]   n_sh [3];
    logic [2:0][WORD_W-1:0]   n_shift;
    logic [2:0][WORD_W-1:0]   r_shift;
    logic                     r_p_v, r_s_v, r_o_v;
    logic [SIDE_W-1:0]        r_p_side, r_s_side, r_o_side;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_p[r][c] = $signed(i_axis[r][c]) * $signed(i_eye[c]);
            end
        end
    end

    // Round half up, then clamp to the signed 32-bit range.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_t[r]  = HALF - T_W'(r_s[r]);
            n_sh[r] = SH_W'(n_t[r] >>> UNIT_FRAC);
            if (n_sh[r] > SAT_MAX) begin
                n_shift[r] = WORD_W'(SAT_MAX);
            end else if (n_sh[r] < SAT_MIN) begin
                n_shift[r] = WORD_W'(SAT_MIN);
            end else begin
                n_shift[r] = WORD_W'(n_sh[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_s_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= i_valid;
            r_s_v <= r_p_v;
            r_o_v <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p      <= n_p;
            r_p_side <= i_side;
            for (int r = 0; r < 3; r++) begin
                r_s[r] <= r_p[r][0] + r_p[r][1] + r_p[r][2];
            end
            r_s_side <= r_p_side;
            r_shift  <= n_shift;
            r_o_side <= r_s_side;
        end
    end

    assign o_valid = r_o_v;
    assign o_shift = r_shift;
    assign o_side  = r_o_side;

endmodule

[rtl/lookat_view_matrix.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds the camera basis and translation column from eye, target and up.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   eye, target, upward (Q16.16)
//   output    out        o_valid / i_stall   right, camup, back (Q2.30),
//                                             shift (Q16.16, saturated)
//
// One beat enters per clock while o_stall is low, and beats leave in the order
// they were taken. Most of the pipeline lies in the three normalizers in
// series, each a 16-stage square root followed by a 16-stage divider, two
// result bits per stage.
// Reset (synchronous, active low) clears every valid bit; data registers keep
// whatever they hold. A stall on the output freezes the whole pipeline through
// one shared enable; a skid register behind the output register lets the
// pipeline hand over one more beat, so o_stall is a plain register output.
//
module lookat_view_matrix
    import lvm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_valid,
    output logic               o_stall,
    input  logic [WORD_W-1:0]  i_eye_x,
    input  logic [WORD_W-1:0]  i_eye_y,
    input  logic [WORD_W-1:0]  i_eye_z,
    input  logic [WORD_W-1:0]  i_target_x,
    input  logic [WORD_W-1:0]  i_target_y,
    input  logic [WORD_W-1:0]  i_target_z,
    input  logic [WORD_W-1:0]  i_upward_x,
    input  logic [WORD_W-1:0]  i_upward_y,
    input  logic [WORD_W-1:0]  i_upward_z,

    output logic               o_valid,
    input  logic               i_stall,
    output logic [WORD_W-1:0]  o_right_x,
    output logic [WORD_W-1:0]  o_right_y,
    output logic [WORD_W-1:0]  o_right_z,
    output logic [WORD_W-1:0]  o_camup_x,
    output logic [WORD_W-1:0]  o_camup_y,
    output logic [WORD_W-1:0]  o_camup_z,
    output logic [WORD_W-1:0]  o_back_x,
    output logic [WORD_W-1:0]  o_back_y,
    output logic [WORD_W-1:0]  o_back_z,
    output logic [WORD_W-1:0]  o_shift_x,
    output logic [WORD_W-1:0]  o_shift_y,
    output logic [WORD_W-1:0]  o_shift_z
);

`include "lookat_view_matrix_assert.svh"

    localparam int VEC_W  = 3 * WORD_W;
    localparam int DIFF_W = WORD_W + 1;
    localparam int SA_W   = 2 * VEC_W;
    localparam int SB_W   = 2 * VEC_W + 1;
    localparam int SC_W   = 3 * VEC_W + 1;

    typedef struct packed {
        logic [2:0][WORD_W-1:0] right;
        logic [2:0][WORD_W-1:0] camup;
        logic [2:0][WORD_W-1:0] back;
        logic [2:0][WORD_W-1:0] shift;
    } t_view;

    // The whole pipeline moves together; it halts only while the skid
    // register holds a beat.
    logic en;

    // Input register: eye, up and the eye-to-target difference.
    logic                    r_in_v;
    logic [2:0][WORD_W-1:0]  r_eye;
    logic [2:0][WORD_W-1:0]  r_up;
    logic [2:0][DIFF_W-1:0]  r_diff;

    // Back axis.
    logic                    a_valid, a_zero;
    logic [2:0][WORD_W-1:0]  a_back;
    logic [2:0][WORD_W-1:0]  a_eye, a_up;

    // Up cross back.
    logic                    c1_valid, c1_zero;
    logic [2:0][PROD_W-1:0]  c1_vec;
    logic [2:0][WORD_W-1:0]  c1_eye, c1_back;

    // Right axis.
    logic                    b_valid, b_zero, b_zero_prev;
    logic [2:0][WORD_W-1:0]  b_right, b_eye, b_back;

    // Back cross right.
    logic                    c2_valid, c2_zero;
    logic [2:0][PROD_W-1:0]  c2_vec;
    logic [2:0][WORD_W-1:0]  c2_eye, c2_back, c2_right;

    // Camera up axis.
    logic                    u_valid, u_zero, u_zero_prev;
    logic [2:0][WORD_W-1:0]  u_camup, u_eye, u_back, u_right;

    // Translation.
    logic                    x_valid, x_zero;
    logic [2:0][WORD_W-1:0]  x_shift, x_right, x_camup, x_back;

    t_view                   n_view;
    t_view                   r_out;
    t_view                   r_skid;
    logic                    r_ov;
    logic                    r_skv;
    logic                    out_take;

    assign en      = !r_skv;
    assign o_stall = r_skv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_eye     <= {i_eye_z, i_eye_y, i_eye_x};
            r_up      <= {i_upward_z, i_upward_y, i_upward_x};
            r_diff[0] <= {i_eye_x[WORD_W-1], i_eye_x} - {i_target_x[WORD_W-1], i_target_x};
            r_diff[1] <= {i_eye_y[WORD_W-1], i_eye_y} - {i_target_y[WORD_W-1], i_target_y};
            r_diff[2] <= {i_eye_z[WORD_W-1], i_eye_z} - {i_target_z[WORD_W-1], i_target_z};
        end
    end

    lvm_norm #(.IN_W(DIFF_W), .SIDE_W(SA_W)) u_norm_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_v),
        .i_vec   (r_diff),
        .i_side  ({r_eye, r_up}),
        .o_valid (a_valid),
        .o_unit  (a_back),
        .o_zero  (a_zero),
        .o_side  ({a_eye, a_up})
    );

    lvm_cross #(.SIDE_W(SB_W)) u_cross_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (a_valid),
        .i_a     (a_up),
        .i_b     (a_back),
        .i_side  ({a_eye, a_back, a_zero}),
        .o_valid (c1_valid),
        .o_c     (c1_vec),
        .o_side  ({c1_eye, c1_back, c1_zero})
    );

    lvm_norm #(.IN_W(PROD_W), .SIDE_W(SB_W)) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c1_valid),
        .i_vec   (c1_vec),
        .i_side  ({c1_eye, c1_back, c1_zero}),
        .o_valid (b_valid),
        .o_unit  (b_right),
        .o_zero  (b_zero),
        .o_side  ({b_eye, b_back, b_zero_prev})
    );

    lvm_cross #(.SIDE_W(SC_W)) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (b_valid),
        .i_a     (b_back),
        .i_b     (b_right),
        .i_side  ({b_eye, b_back, b_right, b_zero | b_zero_prev}),
        .o_valid (c2_valid),
        .o_c     (c2_vec),
        .o_side  ({c2_eye, c2_back, c2_right, c2_zero})
    );

    lvm_norm #(.IN_W(PROD_W), .SIDE_W(SC_W)) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c2_valid),
        .i_vec   (c2_vec),
        .i_side  ({c2_eye, c2_back, c2_right, c2_zero}),
        .o_valid (u_valid),
        .o_unit  (u_camup),
        .o_zero  (u_zero),
        .o_side  ({u_eye, u_back, u_right, u_zero_prev})
    );

    lvm_xlate #(.SIDE_W(SC_W)) u_xlate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (u_valid),
        .i_axis  ({u_back, u_camup, u_right}),
        .i_eye   (u_eye),
        .i_side  ({u_right, u_camup, u_back, u_zero | u_zero_prev}),
        .o_valid (x_valid),
        .o_shift (x_shift),
        .o_side  ({x_right, x_camup, x_back, x_zero})
    );

    // Any zero-length vector along the way blanks the whole matrix.
    always_comb begin
        if (x_zero) begin
            n_view = '0;
        end else begin
            n_view.right = x_right;
            n_view.camup = x_camup;
            n_view.back  = x_back;
            n_view.shift = x_shift;
        end
    end

    // Output register with one skid entry behind it.
    assign out_take = r_ov && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (r_skv) begin
            if (out_take) begin
                r_skv <= 1'b0;
            end
        end else if (x_valid) begin
            if (r_ov && !out_take) begin
                r_skv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (out_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skv) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (x_valid) begin
            if (r_ov && !out_take) begin
                r_skid <= n_view;
            end else begin
                r_out <= n_view;
            end
        end
    end

    assign o_valid   = r_ov;
    assign o_right_x = r_out.right[0];
    assign o_right_y = r_out.right[1];
    assign o_right_z = r_out.right[2];
    assign o_camup_x = r_out.camup[0];
    assign o_camup_y = r_out.camup[1];
    assign o_camup_z = r_out.camup[2];
    assign o_back_x  = r_out.back[0];
    assign o_back_y  = r_out.back[1];
    assign o_back_z  = r_out.back[2];
    assign o_shift_x = r_out.shift[0];
    assign o_shift_y = r_out.shift[1];
    assign o_shift_z = r_out.shift[2];

    // The skid entry is only ever filled behind a waiting output beat.
    `LVM_ASSERT_IMPL(a_skid_behind_out, r_skv, r_ov, "skid holds a beat with no output beat")
    // Once the output beat is taken, the skid beat moves up and the skid empties.
    `LVM_ASSERT_NEXT(a_skid_drains, r_skv && !i_stall, r_ov && !r_skv, "skid did not drain")
    // A blank back axis only comes from a degenerate input; then all fields are zero.
    `LVM_ASSERT_IMPL(a_blank_matrix, o_valid && o_back_x == '0 && o_back_y == '0 && o_back_z == '0, o_right_x == '0 && o_camup_y == '0 && o_shift_x == '0 && o_shift_z == '0, "partial blank matrix")

endmodule

[tb/tb_lookat_view_matrix.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Sends eye, target and up beats into the block, predicts every view matrix
// with a bit-exact fixed-point model and compares each output beat with it,
// in order, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_lookat_view_matrix;
    import lvm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 140;   // longer than the pipeline latency
    localparam longint UNIT       = 64'sd1 << UNIT_FRAC;

    // One input beat: eye xyz, target xyz, upward xyz, in port order.
    typedef logic [8:0][WORD_W-1:0]  t_item;
    // One view matrix: right, camup, back (Q2.30), shift (Q16.16).
    typedef logic [11:0][WORD_W-1:0] t_view;
    typedef longint t_vec [3];

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    t_item drive_item = '0;
    t_view out_view;

    t_view  matrix_queue[$];
    bit     calm = 1'b0;          // when set, neither side idles
    int     beats_sent = 0;
    int     beats_checked = 0;
    int     degenerate_seen = 0;
    int     saturated_seen = 0;
    int     error_count = 0;
    int     quiet_cycles = 0;

    string field_name [12] = '{"right_x", "right_y", "right_z", "camup_x", "camup_y",
                               "camup_z", "back_x", "back_y", "back_z",
                               "shift_x", "shift_y", "shift_z"};

    always #4 i_clk = ~i_clk;

    lookat_view_matrix uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_eye_x    (drive_item[0]),
        .i_eye_y    (drive_item[1]),
        .i_eye_z    (drive_item[2]),
        .i_target_x (drive_item[3]),
        .i_target_y (drive_item[4]),
        .i_target_z (drive_item[5]),
        .i_upward_x (drive_item[6]),
        .i_upward_y (drive_item[7]),
        .i_upward_z (drive_item[8]),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_right_x  (out_view[0]),
        .o_right_y  (out_view[1]),
        .o_right_z  (out_view[2]),
        .o_camup_x  (out_view[3]),
        .o_camup_y  (out_view[4]),
        .o_camup_z  (out_view[5]),
        .o_back_x   (out_view[6]),
        .o_back_y   (out_view[7]),
        .o_back_z   (out_view[8]),
        .o_shift_x  (out_view[9]),
        .o_shift_y  (out_view[10]),
        .o_shift_z  (out_view[11])
    );

    // Bit-by-bit integer square root, floor of the exact root.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Scales the vector so its largest magnitude peaks at bit 30, then divides
    // by the truncated length with rounding. Returns 0 for a zero vector.
    function automatic bit unit_vector(input t_vec v, output t_vec u);
        longint unsigned mag [3];
        bit              neg [3];
        longint unsigned top, sum, len, q;
        int              p;
        top = 0;
        sum = 0;
        p = 0;
        u = '{0, 0, 0};
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > top) top = mag[i];
        end
        if (top == 0) return 1'b0;
        while (p < 63 && (top >> (p + 1)) != 0) p++;
        for (int i = 0; i < 3; i++) begin
            if (p > TOP_BIT) mag[i] >>= (p - TOP_BIT);
            else mag[i] <<= (TOP_BIT - p);
            sum += mag[i] * mag[i];
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << UNIT_FRAC) + (len >> 1)) / len;
            if (q > UNIT) q = UNIT;
            u[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross_product(input t_vec a, input t_vec b, output t_vec c);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Minus the dot product, rounded half up out of Q2.30, saturated to 32 bits.
    function automatic logic [WORD_W-1:0] shift_entry(input t_vec axis, input t_vec eye,
                                                      inout bit clipped);
        longint r;
        r = -(axis[0] * eye[0] + axis[1] * eye[1] + axis[2] * eye[2]) + (UNIT >>> 1);
        r = r >>> UNIT_FRAC;
        if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            clipped = 1'b1;
        end
        if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            clipped = 1'b1;
        end
        return r[WORD_W-1:0];
    endfunction

    function automatic t_view view_matrix(input t_item it, output bit flat, output bit clipped);
        t_vec  eye, diff, up, back, rx, right, ux, camup;
        t_view m;
        bit    ok;
        longint s;
        m = '0;
        clipped = 1'b0;
        for (int i = 0; i < 3; i++) begin
            eye[i]  = $signed(it[i]);
            s       = $signed(it[3 + i]);
            diff[i] = eye[i] - s;
            up[i]   = $signed(it[6 + i]);
        end
        ok = unit_vector(diff, back);
        if (ok) begin
            cross_product(up, back, rx);
            ok = unit_vector(rx, right);
        end
        if (ok) begin
            cross_product(back, right, ux);
            ok = unit_vector(ux, camup);
        end
        flat = !ok;
        if (!ok) return m;
        for (int i = 0; i < 3; i++) begin
            m[i]     = right[i][WORD_W-1:0];
            m[3 + i] = camup[i][WORD_W-1:0];
            m[6 + i] = back[i][WORD_W-1:0];
        end
        m[9]  = shift_entry(right, eye, clipped);
        m[10] = shift_entry(camup, eye, clipped);
        m[11] = shift_entry(back, eye, clipped);
        return m;
    endfunction

    // Sends one beat, possibly after a short random gap, and records the
    // matrix it should produce once the block has taken it.
    task automatic send_item(input t_item it);
        bit flat, clipped;
        t_view m;
        if (!calm && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        drive_item <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        m = view_matrix(it, flat, clipped);
        matrix_queue.push_back(m);
        beats_sent++;
        if (flat) degenerate_seen++;
        if (clipped) saturated_seen++;
    endtask

    function automatic logic [WORD_W-1:0] small_word(input int span);
        return WORD_W'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    mode;
        mode = $urandom_range(0, 99);
        for (int i = 0; i < 9; i++) it[i] = $urandom();
        if (mode < 25) begin
            // Scene sized coordinates, the usual camera case.
            for (int i = 0; i < 9; i++) it[i] = small_word(1 << 22);
        end else if (mode < 32) begin
            // Eye on the target.
            it[3] = it[0];
            it[4] = it[1];
            it[5] = it[2];
        end else if (mode < 40) begin
            // Up along the view direction.
            for (int i = 0; i < 3; i++) begin
                it[i]     = small_word(1 << 20);
                it[3 + i] = small_word(1 << 20);
                it[6 + i] = WORD_W'(($signed(it[i]) - $signed(it[3 + i])) * $urandom_range(1, 3));
            end
        end else if (mode < 44) begin
            it[6 + $urandom_range(0, 2)] = '0;
        end
        return it;
    endfunction

    task automatic test_degenerate();
        t_item it;
        it = '0;
        send_item(it);                                  // all zero
        it = {32'd3 << 16, 32'd2 << 16, 32'd1 << 16,    // eye equals target
              32'd7 << 16, 32'd5 << 16, 32'd9 << 16, 32'd7 << 16, 32'd5 << 16, 32'd9 << 16};
        send_item(it);
        it = '0;
        it[2] = 32'd5 << 16;                            // zero up vector
        send_item(it);
        it[7] = 32'd0;
        it[8] = 32'd1 << 16;                            // up along the view axis
        send_item(it);
        it[8] = -(32'd3 << 16);                         // up against the view axis
        send_item(it);
    endtask

    task automatic test_extremes();
        t_item it;
        logic [WORD_W-1:0] pick [4] = '{32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00000001};
        it = '0;
        it[2] = 32'd5 << 16;
        it[7] = 32'd1 << 16;
        send_item(it);                                  // textbook camera on +z
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 9; i++) it[i] = pick[(k + i) % 4];
            send_item(it);
        end
        // Eye and target at opposite corners: the largest difference.
        it = {32'h00000000, 32'h00010000, 32'h00000000, {3{32'h80000000}}, {3{32'h7fffffff}}};
        send_item(it);
        it = {32'h00010000, 32'h00000000, 32'h00000000, {3{32'h7fffffff}}, {3{32'h80000000}}};
        send_item(it);
        // Far eye on a diagonal: translation leaves the 32-bit range.
        it = {32'h00000000, 32'h7fffffff, 32'h00000000, {3{32'h00000000}}, {3{32'h7fffffff}}};
        send_item(it);
        it = {32'h7fffffff, 32'h00000000, 32'h00000000, {3{32'h00000000}}, {3{32'h80000000}}};
        send_item(it);
        it = {32'h00000000, 32'h00010000, 32'h00000000, {3{32'h00000000}}, {3{32'h80000000}}};
        send_item(it);
        for (int i = 0; i < 8; i++) begin
            it = {9{32'h0}};
            it[$urandom_range(0, 8)] = 32'h80000000 >> $urandom_range(0, 31);
            it[$urandom_range(0, 8)] = ~32'h0;
            send_item(it);
        end
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) send_item(random_item());
    endtask

    task automatic test_back_to_back(input int count);
        calm = 1'b1;
        for (int n = 0; n < count; n++) send_item(random_item());
        calm = 1'b0;
    endtask

    // Output side: random short stalls except during the calm stretch.
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 6);
    end

    // Compare every accepted output beat with the oldest expected matrix.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (matrix_queue.size() == 0) begin
                $display("%0t: output beat with no matrix expected", $realtime);
                error_count++;
            end else begin
                t_view want;
                want = matrix_queue.pop_front();
                for (int i = 0; i < 12; i++) begin
                    if (out_view[i] !== want[i]) begin
                        $display("%0t: %s expected %h actual %h", $realtime,
                                 field_name[i], want[i], out_view[i]);
                        error_count++;
                    end
                end
            end
            beats_checked++;
        end
    end

    // Watchdog: too long without a beat taken on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_degenerate();
        test_extremes();
        test_random(600);
        test_back_to_back(250);
        test_random(180);
        i_valid <= 1'b0;
        while (matrix_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d beats, checked %0d matrices (%0d degenerate, %0d saturated).",
                 beats_sent, beats_checked, degenerate_seen, saturated_seen);
        $display("Random idling on both sides plus one back-to-back stretch.");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/lvm_pkg.sv
rtl/lvm_norm.sv
rtl/lvm_cross.sv
rtl/lvm_xlate.sv
rtl/lookat_view_matrix.sv
tb/tb_lookat_view_matrix.sv
